// ----- hw/rtl/dfbd_pkg.sv -----
package dfbd_pkg;

    localparam logic [7:0] FLAG_RESET  = 8'h7E;
    localparam int         WINDOW_BITS = 8;
    localparam int         TRIM_BITS   = 7;
    localparam int         QUEUE_DEPTH = 4;

    // What the front part has made of one bit on the line.
    typedef enum logic [1:0] {
        OP_PAYLOAD = 2'd0,
        OP_OPEN    = 2'd1,
        OP_CLOSE   = 2'd2
    } t_op_kind;

    typedef struct packed {
        t_op_kind kind;
        logic     data;
    } t_op;

    // Status flags the queue gives its producer and its consumer.
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

// ----- hw/rtl/flag_delimited_bit_deframer_top.sv -----
// Flag-delimited bit deframer. Bytes arrive on i_data_byte and are examined one bit per
// cycle (unless the queue is full), most significant first, against the flag held in the
// register written through i_wr_en/i_wr_data (0x7E after reset). The first flag opens a
// frame and the next closes it; the payload bits in between leave one per beat on
// o_payload_bit, the final bit of a closed frame marked by o_frame_last. No bit destuffing
// is done. The front end serialises each byte, and the next byte is taken in the cycle the
// previous one finishes. A closing flag that ends a frame of fewer than seven bits holds
// the back end while it releases those bits; a small queue between the two ends absorbs
// this and any stall on the output side.
module flag_delimited_bit_deframer_top
    import dfbd_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_wr_en,
    input  logic [7:0] i_wr_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_payload_bit,
    output logic       o_frame_last
);

    t_queue_status q_status;
    t_op           push_op;
    t_op           head_op;
    logic          push;
    logic          pop;

    dfbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_wr_en     (i_wr_en),
        .i_wr_data   (i_wr_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_op        (push_op)
    );

    dfbd_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (push_op),
        .i_pop    (pop),
        .o_head   (head_op),
        .o_status (q_status)
    );

    dfbd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (head_op),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_payload_bit (o_payload_bit),
        .o_frame_last  (o_frame_last)
    );

endmodule

// ----- hw/rtl/dfbd_queue.sv -----
module dfbd_queue
    import dfbd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_op           i_op,
    input  logic          i_pop,
    output t_op           o_head,
    output t_queue_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);

    t_op              r_mem [DEPTH];
    logic [PTR_W:0]   r_wr_ptr;
    logic [PTR_W:0]   r_rd_ptr;
    logic             full;
    logic             empty;

    assign empty = (r_wr_ptr == r_rd_ptr);
    assign full  = (r_wr_ptr[PTR_W] != r_rd_ptr[PTR_W]) &&
                   (r_wr_ptr[PTR_W-1:0] == r_rd_ptr[PTR_W-1:0]);

    assign o_head         = r_mem[r_rd_ptr[PTR_W-1:0]];
    assign o_status.empty = empty;
    assign o_status.full  = full;

    always_ff @(posedge i_clk) begin
        if (i_push && !full) begin
            r_mem[r_wr_ptr[PTR_W-1:0]] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !full) begin
                r_wr_ptr <= r_wr_ptr + (PTR_W + 1)'(1);
            end
            if (i_pop && !empty) begin
                r_rd_ptr <= r_rd_ptr + (PTR_W + 1)'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !i_push)
        else $error("queue pushed while full");
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty |-> !i_pop)
        else $error("queue popped while empty");
`endif

endmodule

// ----- hw/rtl/dfbd_front.sv -----
module dfbd_front
    import dfbd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_wr_en,
    input  logic [7:0]    i_wr_data,
    input  t_queue_status i_q_status,
    output logic          o_push,
    output t_op           o_op
);

    logic [7:0] r_flag;
    logic [7:0] r_hist;
    logic       r_inside;
    logic [7:0] r_shift;
    logic [2:0] r_idx;
    logic       r_busy;

    logic [7:0] hist_next;
    logic       match;
    logic       advance;
    logic       accept;

    assign hist_next = {r_hist[6:0], r_shift[7]};
    assign match     = (hist_next == r_flag);
    assign advance   = r_busy && !i_q_status.full;
    assign o_ready   = !r_busy || (advance && (r_idx == 3'd7));
    assign accept    = i_valid && o_ready;

    // Bits outside a frame that do not match the flag leave no trace downstream.
    assign o_push = advance && (match || r_inside);

    always_comb begin
        o_op.data = r_shift[7];
        if (match) begin
            o_op.kind = r_inside ? OP_CLOSE : OP_OPEN;
        end else begin
            o_op.kind = OP_PAYLOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag   <= FLAG_RESET;
            r_hist   <= '0;
            r_inside <= 1'b0;
            r_idx    <= '0;
            r_busy   <= 1'b0;
            r_shift  <= '0;
        end else begin
            if (i_wr_en) begin
                r_flag <= i_wr_data;
            end
            if (advance) begin
                r_hist <= hist_next;
                if (match) begin
                    r_inside <= !r_inside;
                end
            end
            if (accept) begin
                r_shift <= i_data_byte;
                r_idx   <= '0;
                r_busy  <= 1'b1;
            end else if (advance) begin
                r_shift <= {r_shift[6:0], 1'b0};
                r_idx   <= r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_inside_moves_on_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(advance && match) |=> $stable(r_inside))
        else $error("frame state changed without a flag match");
    a_accept_only_at_byte_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_busy) |-> (r_idx == 3'd7 && advance))
        else $error("beat accepted before the previous byte was serialised");
`endif

endmodule

// ----- hw/rtl/dfbd_back.sv -----
module dfbd_back
    import dfbd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_op           i_op,
    input  t_queue_status i_q_status,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_payload_bit,
    output logic          o_frame_last
);

    logic [7:0] r_win;
    logic [3:0] r_cnt;
    logic [2:0] r_drain;
    logic       r_out_valid;
    logic       r_out_bit;
    logic       r_out_last;

    logic [7:0] n_win;
    logic [3:0] n_cnt;
    logic [2:0] n_drain;
    logic       emit;
    logic       emit_bit;
    logic       emit_last;
    logic       out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = out_free && !i_q_status.empty && (r_drain == 3'd0);

    always_comb begin
        n_win     = r_win;
        n_cnt     = r_cnt;
        n_drain   = r_drain;
        emit      = 1'b0;
        emit_bit  = 1'b0;
        emit_last = 1'b0;
        if (out_free && (r_drain != 3'd0)) begin
            // A short frame is released oldest bit first, the newest marked last.
            emit      = 1'b1;
            emit_bit  = r_win[r_drain - 3'd1];
            emit_last = (r_drain == 3'd1);
            n_drain   = r_drain - 3'd1;
        end else if (o_pop) begin
            case (i_op.kind)
                OP_OPEN: begin
                    n_cnt = '0;
                end
                OP_PAYLOAD: begin
                    if (r_cnt == 4'(WINDOW_BITS)) begin
                        emit     = 1'b1;
                        emit_bit = r_win[7];
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                    n_win = {r_win[6:0], i_op.data};
                end
                OP_CLOSE: begin
                    // The seven newest held bits belong to the closing flag.
                    if (r_cnt == 4'(WINDOW_BITS)) begin
                        emit      = 1'b1;
                        emit_bit  = r_win[7];
                        emit_last = 1'b1;
                    end else if (r_cnt < 4'(TRIM_BITS)) begin
                        n_drain = r_cnt[2:0];
                    end
                    n_cnt = '0;
                end
                default: begin
                    n_cnt = r_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_cnt       <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_win   <= n_win;
            r_cnt   <= n_cnt;
            r_drain <= n_drain;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && emit) begin
            r_out_bit  <= emit_bit;
            r_out_last <= emit_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_payload_bit = r_out_bit;
    assign o_frame_last  = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(WINDOW_BITS))
        else $error("held bit count beyond the window");
    a_drain_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drain != 3'd0) |-> (r_cnt == 4'd0 && !o_pop))
        else $error("window touched while a short frame drains");
`endif

endmodule

// ----- dv/flag_delimited_bit_deframer_top_tb.sv -----
module flag_delimited_bit_deframer_top_tb
    import dfbd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PREDICTED    = -1;
    localparam int DRAIN_CYCLES = 48;
    localparam int PHASE_BYTES  = 13;
    localparam int MAX_WAIT     = 11;

    typedef enum logic {
        ROW_BYTE,
        ROW_FLAG
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [7:0]  value;
        int          n_typed;
        logic [15:0] typed_bits;
        logic [15:0] typed_last;
    } t_stim_row;

    typedef struct packed {
        logic payload_bit;
        logic frame_last;
    } t_bit_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_data_byte;
    logic       i_wr_en;
    logic [7:0] i_wr_data;
    logic       o_valid;
    logic       i_ready;
    logic       o_payload_bit;
    logic       o_frame_last;

    flag_delimited_bit_deframer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_wr_en       (i_wr_en),
        .i_wr_data     (i_wr_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_payload_bit (o_payload_bit),
        .o_frame_last  (o_frame_last)
    );

    // Local copy of the deframer state.
    logic [7:0] flag_now;
    logic [7:0] line_history;
    logic       in_frame;
    logic [7:0] held_bits;
    logic [3:0] held_num;

    t_bit_beat  expected_beats[$];
    t_stim_row  directed_rows[$];

    int errors;
    int bytes_sent;
    int beats_checked;
    int frames_closed;
    int flags_written;
    bit no_idle;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_stim_row mk_row(t_row_kind kind, logic [7:0] value, int n_typed,
                                         logic [15:0] typed_bits, logic [15:0] typed_last);
        t_stim_row r;
        r.kind       = kind;
        r.value      = value;
        r.n_typed    = n_typed;
        r.typed_bits = typed_bits;
        r.typed_last = typed_last;
        return r;
    endfunction

    task automatic add_row(input t_stim_row r);
        directed_rows.insert(directed_rows.size(), r);
    endtask

    task automatic push_beat(input logic bit_val, input logic last);
        t_bit_beat e;
        e.payload_bit = bit_val;
        e.frame_last  = last;
        expected_beats.insert(expected_beats.size(), e);
    endtask

    task automatic close_held_frame();
        int c;
        c = held_num;
        if (c >= WINDOW_BITS) begin
            push_beat(held_bits[7], 1'b1);
        end else if (c < TRIM_BITS) begin
            // A short frame goes out whole, oldest bit first.
            while (c > 0) begin
                c--;
                push_beat(held_bits[c], c == 0);
            end
        end
        held_num  = '0;
        held_bits = '0;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic line_bit;
        for (int i = 7; i >= 0; i--) begin
            line_bit     = b[i];
            line_history = {line_history[6:0], line_bit};
            if (line_history == flag_now) begin
                if (!in_frame) begin
                    in_frame  = 1'b1;
                    held_num  = '0;
                    held_bits = '0;
                end else begin
                    in_frame = 1'b0;
                    close_held_frame();
                end
            end else if (in_frame) begin
                // A bit leaves only once eight newer ones stand behind it.
                if (held_num >= WINDOW_BITS) begin
                    push_beat(held_bits[7], 1'b0);
                end else begin
                    held_num++;
                end
                held_bits = {held_bits[6:0], line_bit};
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    // The flag may change only once the block has gone quiet.
    task automatic set_flag(input logic [7:0] v);
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_wr_en   <= 1'b1;
        i_wr_data <= v;
        @(posedge i_clk);
        i_wr_en  <= 1'b0;
        flag_now = v;
        flags_written++;
    endtask

    task automatic send_predicted(input logic [7:0] b);
        send_byte(b);
        deframe_byte(b);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        i_wr_en     = 1'b0;
        i_wr_data   = '0;
        i_ready     = 1'b0;
    end

    // Output side: random stalls, each beat checked against the oldest expectation.
    initial begin : result_side
        int        gap;
        t_bit_beat e;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, payload_bit=%0b frame_last=%0b",
                         $realtime, o_payload_bit, o_frame_last);
                errors++;
            end else begin
                e = expected_beats.pop_front();
                beats_checked++;
                if (o_payload_bit !== e.payload_bit) begin
                    $display("%0t: payload_bit mismatch, expected %0b, actual %0b",
                             $realtime, e.payload_bit, o_payload_bit);
                    errors++;
                end
                if (o_frame_last !== e.frame_last) begin
                    $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                             $realtime, e.frame_last, o_frame_last);
                    errors++;
                end
                if (e.frame_last) frames_closed++;
            end
        end
    end

    initial begin : stimulus
        int         n0;
        int         phase_count;
        int         n_payload;
        logic [7:0] phase_flags[6];

        errors        = 0;
        bytes_sent    = 0;
        beats_checked = 0;
        frames_closed = 0;
        flags_written = 0;
        no_idle       = 1'b0;
        flag_now      = FLAG_RESET;
        line_history  = '0;
        in_frame      = 1'b0;
        held_bits     = '0;
        held_num      = '0;

        // After reset: a zero byte is noise, then a flag opens, and a flag straight after
        // it closes with seven bits held, so nothing comes out. The next frame carries
        // 0x00 then 0xFF, so the ones push out eight zeros and the closing flag the ones.
        add_row(mk_row(ROW_BYTE, 8'h00, 0, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'h7E, 0, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'h7E, 0, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'h7E, 0, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'h00, 0, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'hFF, 8, 16'h0000, 16'h0000));
        add_row(mk_row(ROW_BYTE, 8'h7E, 8, 16'h00FF, 16'h0080));
        add_row(mk_row(ROW_BYTE, 8'h7E, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'hA5, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'h7E, PREDICTED, '0, '0));
        // An alternating flag overlaps itself, which gives short frames.
        add_row(mk_row(ROW_FLAG, 8'hAA, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'hAA, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'hA9, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'h6A, PREDICTED, '0, '0));
        // An all-ones flag re-matches on every one, which gives empty frames.
        add_row(mk_row(ROW_FLAG, 8'hFF, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'hFF, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'hFF, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'h3C, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'hFF, PREDICTED, '0, '0));
        add_row(mk_row(ROW_FLAG, 8'h00, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'h00, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'h81, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'h00, PREDICTED, '0, '0));
        // The flag goes back and a frame is left open with bits already released.
        add_row(mk_row(ROW_FLAG, 8'h7E, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'h7E, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'h5A, PREDICTED, '0, '0));
        add_row(mk_row(ROW_BYTE, 8'hC3, PREDICTED, '0, '0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_FLAG) begin
                set_flag(directed_rows[r].value);
            end else begin
                send_byte(directed_rows[r].value);
                n0 = expected_beats.size();
                deframe_byte(directed_rows[r].value);
                if (directed_rows[r].n_typed != PREDICTED) begin
                    while (expected_beats.size() > n0)
                        expected_beats.delete(expected_beats.size() - 1);
                    for (int k = 0; k < directed_rows[r].n_typed; k++)
                        push_beat(directed_rows[r].typed_bits[k],
                                  directed_rows[r].typed_last[k]);
                end
            end
        end

        phase_flags[0] = 8'h7E;
        phase_flags[1] = 8'($urandom_range(0, 255));
        phase_flags[2] = 8'h00;
        phase_flags[3] = 8'hFF;
        phase_flags[4] = 8'hAA;
        phase_flags[5] = 8'($urandom_range(0, 255));

        for (int p = 0; p < 6; p++) begin
            set_flag(phase_flags[p]);
            no_idle     = (p == 2);
            phase_count = 0;
            while (phase_count < PHASE_BYTES) begin
                if ($urandom_range(0, 3) != 0) begin
                    // Flag, random payload, flag.
                    n_payload = $urandom_range(0, 4);
                    send_predicted(flag_now);
                    for (int k = 0; k < n_payload; k++)
                        send_predicted(8'($urandom_range(0, 255)));
                    send_predicted(flag_now);
                    phase_count += n_payload + 2;
                end else begin
                    n_payload = $urandom_range(1, 3);
                    for (int k = 0; k < n_payload; k++)
                        send_predicted(8'($urandom_range(0, 255)));
                    phase_count += n_payload;
                end
            end
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;

        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes under %0d flag settings; checked %0d payload beats",
                 bytes_sent, flags_written + 1, beats_checked);
        $display("Frames closed with a last beat: %0d; mismatches: %0d",
                 frames_closed, errors);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
